// ===== hw/rtl/ttf_pkg.sv =====
// ----------------------------------------------------------------------------
// ttf_pkg
// Shared types and constants for the total trace filter: field widths,
// register codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int TAU_W       = 16;
    localparam int RATIO_W     = 16;
    localparam int INTERVAL_W  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int RATIO_FRAC  = 12;
    localparam int T2_W        = TAU_W + 1;
    localparam int SUM_W       = T2_W + 1;
    localparam int PROD_W      = T2_W + RATIO_W;
    localparam int COEF_W      = PROD_W + 2;
    localparam int DEN_W       = SUM_W + RATIO_FRAC;
    localparam int DIGIT_W     = 16;
    localparam int HEAD_W      = COEF_W + 1;

    localparam logic [TAU_W-1:0]   TAU_RESET   = 16'd1280;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TAU   = 1'b0,
        CFG_RATIO = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TERM_RED,
        TERM_BLUE,
        TERM_BPREV,
        TERM_DECAY
    } term_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF,
        ST_MUL,
        ST_DRAIN,
        ST_ABS,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic coef;
        logic mul;
        logic absval;
        logic check;
        logic divide;
        logic round;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_last;
        logic div_last;
        logic sat;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/ttf_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttf_ctrl
// Sequencer for the total trace filter: steps one request through the
// coefficient, multiply-accumulate, divide, round and output phases.
// ----------------------------------------------------------------------------
module ttf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output ttf_pkg::dp_cmd_t    cmd,
    input  ttf_pkg::dp_status_t status
);
    import ttf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_COEF;
                end
            end
            ST_COEF: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (status.mul_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_ABS;
            end
            ST_ABS: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.sat ? ST_ROUND : ST_DIV;
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_COEF: begin
                cmd.coef = 1'b1;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_ABS: begin
                cmd.absval = 1'b1;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_DIV: begin
                cmd.divide = 1'b1;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
            end
            ST_OUT: begin
                cmd.commit = !status.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/ttf_datapath.sv =====
// ----------------------------------------------------------------------------
// ttf_datapath
// Datapath of the total trace filter: configuration registers, trace history,
// coefficient build, digit-serial multiply-accumulate of the numerator,
// bit-serial restoring divider, rounding, saturation and output register.
// ----------------------------------------------------------------------------
module ttf_datapath #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ttf_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_first_frame,
    input  logic [ttf_pkg::INTERVAL_W-1:0]      s_frame_interval,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_red_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_blue_sample,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic signed [SAMPLE_WIDTH-1:0]      m_trace_value,
    input  ttf_pkg::dp_cmd_t                    cmd,
    output ttf_pkg::dp_status_t                 status
);
    import ttf_pkg::*;

    localparam int OP_W       = SAMPLE_WIDTH + 1;
    localparam int NUM_DIGITS = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int OPX_W      = NUM_DIGITS * DIGIT_W;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int ACC_W      = SAMPLE_WIDTH + HEAD_W;
    localparam int PP_W       = COEF_W + DIGIT_W + 1;
    localparam int DIV_CNT_W  = $clog2(SAMPLE_WIDTH);
    localparam int DSH_W      = INTERVAL_W + RATIO_FRAC;

    localparam logic [DIG_IDX_W-1:0]  DIG_LAST = DIG_IDX_W'(NUM_DIGITS - 1);
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST = DIV_CNT_W'(SAMPLE_WIDTH - 1);
    localparam logic [SAMPLE_WIDTH:0] SAT_POS  = {2'b00, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH:0] SAT_NEG  = {2'b01, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration and history
    logic [TAU_W-1:0]               tau_reg;
    logic [RATIO_W-1:0]             ratio_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_red_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_blue_reg;
    logic signed [SAMPLE_WIDTH-1:0] prev_trace_reg;

    // per request operands and coefficients
    logic [INTERVAL_W-1:0]          d_reg;
    logic signed [OP_W-1:0]         op_red_reg;
    logic signed [OP_W-1:0]         op_blue_reg;
    logic signed [OP_W-1:0]         op_bprev_reg;
    logic signed [OP_W-1:0]         op_decay_reg;
    logic [COEF_W-1:0]              c_red_reg;
    logic [COEF_W-1:0]              c_blue_reg;
    logic [COEF_W-1:0]              c_bprev_reg;
    logic [COEF_W-1:0]              c_decay_reg;
    logic [DEN_W-1:0]               den_reg;

    // multiply-accumulate
    term_t                          term_reg;
    logic [DIG_IDX_W-1:0]           digit_reg;
    logic signed [PP_W-1:0]         pp_reg;
    logic                           pp_vld_reg;
    logic [DIG_IDX_W-1:0]           pp_shift_reg;
    logic [ACC_W-1:0]               acc_reg;

    // divide and round
    logic                           neg_reg;
    logic                           sat_reg;
    logic [DEN_W-1:0]               rem_reg;
    logic [SAMPLE_WIDTH-1:0]        mq_reg;
    logic [DIV_CNT_W-1:0]           div_cnt_reg;
    logic [SAMPLE_WIDTH-1:0]        mag_reg;

    // output register
    logic                           m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_data_reg;

    logic signed [SAMPLE_WIDTH-1:0] red_prev;
    logic signed [SAMPLE_WIDTH-1:0] blue_prev;
    logic signed [SAMPLE_WIDTH-1:0] trace_prev;
    logic [TAU_W-1:0]               tau_eff;
    logic [T2_W-1:0]                t2;
    logic [PROD_W-1:0]              prod;
    logic [DSH_W-1:0]               d_sh;
    logic [COEF_W-1:0]              coef_sel;
    logic signed [OP_W-1:0]         op_sel;
    logic signed [OPX_W-1:0]        op_ext;
    logic [DIGIT_W-1:0]             digit_raw;
    logic signed [DIGIT_W:0]        digit_sel;
    logic signed [PP_W-1:0]         pp_next;
    logic signed [ACC_W-1:0]        pp_ext;
    logic [ACC_W-1:0]               acc_add;
    logic [ACC_W-1:0]               acc_abs;
    logic [HEAD_W-1:0]              head;
    logic [DEN_W:0]                 rem_shift;
    logic                           rem_ge;
    logic [DEN_W:0]                 rem_diff;
    logic [DEN_W-1:0]               rem_next;
    logic                           round_up;
    logic [SAMPLE_WIDTH:0]          qr;
    logic [SAMPLE_WIDTH:0]          limit;
    logic [SAMPLE_WIDTH-1:0]        mag_next;
    logic [SAMPLE_WIDTH-1:0]        y_next;
    term_t                          term_next;

    assign red_prev   = s_first_frame ? '0 : prev_red_reg;
    assign blue_prev  = s_first_frame ? '0 : prev_blue_reg;
    assign trace_prev = s_first_frame ? '0 : prev_trace_reg;

    // coefficients: tau code of zero counts as one
    assign tau_eff = (tau_reg == '0) ? TAU_W'(1) : tau_reg;
    assign t2      = {tau_eff, 1'b0};
    assign prod    = PROD_W'(t2) * PROD_W'(ratio_reg);
    assign d_sh    = {d_reg, {RATIO_FRAC{1'b0}}};

    always_comb begin
        case (term_reg)
            TERM_RED: begin
                coef_sel = c_red_reg;
                op_sel   = op_red_reg;
            end
            TERM_BLUE: begin
                coef_sel = c_blue_reg;
                op_sel   = op_blue_reg;
            end
            TERM_BPREV: begin
                coef_sel = c_bprev_reg;
                op_sel   = op_bprev_reg;
            end
            TERM_DECAY: begin
                coef_sel = c_decay_reg;
                op_sel   = op_decay_reg;
            end
            default: begin
                coef_sel = c_red_reg;
                op_sel   = op_red_reg;
            end
        endcase
    end

    always_comb begin
        case (term_reg)
            TERM_RED:   term_next = TERM_BLUE;
            TERM_BLUE:  term_next = TERM_BPREV;
            TERM_BPREV: term_next = TERM_DECAY;
            TERM_DECAY: term_next = TERM_DECAY;
            default:    term_next = TERM_RED;
        endcase
    end

    // top digit carries the sign, lower digits are unsigned
    assign op_ext    = OPX_W'(op_sel);
    assign digit_raw = op_ext[digit_reg*DIGIT_W +: DIGIT_W];
    assign digit_sel = (digit_reg == DIG_LAST) ? {digit_raw[DIGIT_W-1], digit_raw}
                                               : {1'b0, digit_raw};
    assign pp_next   = $signed(coef_sel) * digit_sel;

    assign pp_ext  = ACC_W'(pp_reg);
    assign acc_add = acc_reg + (pp_ext <<< (pp_shift_reg * DIGIT_W));
    assign acc_abs = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;

    // quotient overflows sample width when the upper part reaches the divisor
    assign head = acc_reg[ACC_W-1:SAMPLE_WIDTH];

    assign rem_shift = {rem_reg, mq_reg[SAMPLE_WIDTH-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_next  = rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];

    // round half away from zero on the magnitude, then clamp
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};
    assign qr       = {1'b0, mq_reg} + (SAMPLE_WIDTH+1)'(round_up);
    assign limit    = neg_reg ? SAT_NEG : SAT_POS;
    assign mag_next = (sat_reg || (qr > limit)) ? limit[SAMPLE_WIDTH-1:0]
                                                : qr[SAMPLE_WIDTH-1:0];
    assign y_next   = neg_reg ? (~mag_reg + SAMPLE_WIDTH'(1)) : mag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_reg        <= TAU_RESET;
            ratio_reg      <= RATIO_RESET;
            prev_red_reg   <= '0;
            prev_blue_reg  <= '0;
            prev_trace_reg <= '0;
            pp_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_wr_index))
                    CFG_TAU:   tau_reg   <= cfg_wr_data;
                    CFG_RATIO: ratio_reg <= cfg_wr_data;
                    default:   tau_reg   <= tau_reg;
                endcase
            end
            if (cmd.load) begin
                prev_red_reg  <= s_red_sample;
                prev_blue_reg <= s_blue_sample;
            end
            if (cmd.commit) begin
                prev_trace_reg <= y_next;
            end
            pp_vld_reg  <= cmd.mul;
            m_valid_reg <= cmd.commit || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg        <= s_frame_interval;
            op_red_reg   <= OP_W'(s_red_sample) - OP_W'(red_prev);
            op_blue_reg  <= OP_W'(s_blue_sample);
            op_bprev_reg <= -OP_W'(blue_prev);
            op_decay_reg <= OP_W'(trace_prev);
            term_reg     <= TERM_RED;
            digit_reg    <= '0;
            acc_reg      <= '0;
        end
        if (cmd.coef) begin
            c_red_reg   <= COEF_W'(t2) << RATIO_FRAC;
            c_blue_reg  <= COEF_W'(prod) + COEF_W'(d_sh);
            c_bprev_reg <= COEF_W'(prod) - COEF_W'(d_sh);
            c_decay_reg <= (COEF_W'(t2) - COEF_W'(d_reg)) << RATIO_FRAC;
            den_reg     <= {SUM_W'(t2) + SUM_W'(d_reg), {RATIO_FRAC{1'b0}}};
        end
        if (cmd.mul) begin
            pp_reg       <= pp_next;
            pp_shift_reg <= digit_reg;
            if (digit_reg == DIG_LAST) begin
                digit_reg <= '0;
                term_reg  <= term_next;
            end else begin
                digit_reg <= digit_reg + DIG_IDX_W'(1);
            end
        end
        if (pp_vld_reg) begin
            acc_reg <= acc_add;
        end
        if (cmd.absval) begin
            neg_reg <= acc_reg[ACC_W-1];
            acc_reg <= acc_abs;
        end
        if (cmd.check) begin
            sat_reg     <= head >= HEAD_W'(den_reg);
            rem_reg     <= head[DEN_W-1:0];
            mq_reg      <= acc_reg[SAMPLE_WIDTH-1:0];
            div_cnt_reg <= '0;
        end
        if (cmd.divide) begin
            rem_reg     <= rem_next;
            mq_reg      <= {mq_reg[SAMPLE_WIDTH-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.round) begin
            mag_reg <= mag_next;
        end
        if (cmd.commit) begin
            m_data_reg <= y_next;
        end
    end

    assign status.mul_last = (term_reg == TERM_DECAY) && (digit_reg == DIG_LAST);
    assign status.div_last = div_cnt_reg == DIV_LAST;
    assign status.sat      = head >= HEAD_W'(den_reg);
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_trace_value = m_data_reg;

endmodule

// ===== hw/rtl/total_trace_filter.sv =====
// ----------------------------------------------------------------------------
// total_trace_filter
// Per-frame total trace recursion with buffering correction, rounded to
// nearest and saturated to the sample width.
// ----------------------------------------------------------------------------
// One frame request at a time. A request passes through coefficient build,
// multiply-accumulate, drain, absolute value, saturation check, divide, round
// and output; the divide is skipped when the result saturates early. The
// numerator is built by the single 35x17 multiplier, one 16-bit digit of one
// term per cycle, and the restoring divider yields one quotient bit per cycle.
// The result sits in an output register, so a new request is taken while it
// waits. The user must write tau_frames and buffer_ratio through the cfg_wr
// port only while no request is in flight; the block itself does not enforce
// this.
module total_trace_filter #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ttf_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [ttf_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_first_frame,
    input  logic [ttf_pkg::INTERVAL_W-1:0]      s_frame_interval,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_red_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_blue_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      m_trace_value
);
    import ttf_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ttf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ttf_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_first_frame    (s_first_frame),
        .s_frame_interval (s_frame_interval),
        .s_red_sample     (s_red_sample),
        .s_blue_sample    (s_blue_sample),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_trace_value    (m_trace_value),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// ===== hw/rtl/ttf_chk.sv =====
// ----------------------------------------------------------------------------
// ttf_chk
// Port-level checks for the total trace filter: request ordering, result
// accounting and output hold; bound onto the top level.
// ----------------------------------------------------------------------------
module ttf_chk #(
    parameter int SAMPLE_WIDTH = 32
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [SAMPLE_WIDTH-1:0]          m_trace_value
);

    logic       s_fire;
    logic       m_fire;
    logic [1:0] inflight_reg;

    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    // requests taken minus results delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 2'(s_fire) - 2'(m_fire);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("request taken on consecutive cycles");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (inflight_reg == 2'd0) || (inflight_reg == 2'd1))
        else $error("request taken while another is in work");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 2'd0)
        else $error("result without a pending request");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_trace_value))
        else $error("stalled result dropped or changed");

endmodule

bind total_trace_filter ttf_chk #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ttf_chk (.*);

// ===== tb/sv/total_trace_filter_tb.sv =====
// ----------------------------------------------------------------------------
// total_trace_filter_tb
// Drives frame requests into the total trace filter under several time
// constant and buffering ratio settings, predicts every trace value with an
// exact wide-integer form of the recursion (round half away from zero, then
// saturate) and checks each result in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module total_trace_filter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttf_pkg::*;

    localparam int SW        = 32;
    localparam int PHASES    = 8;
    localparam int PER_PHASE = 150;
    localparam int SETTLE    = 60;
    localparam int LIMIT     = 1000000;

    typedef struct {
        logic                 first;
        logic [15:0]          interval;
        logic signed [SW-1:0] red;
        logic signed [SW-1:0] blue;
        logic                 drain;
    } frame_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_first_frame = 1'b0;
    logic [INTERVAL_W-1:0]     s_frame_interval = '0;
    logic signed [SW-1:0]      s_red_sample = '0;
    logic signed [SW-1:0]      s_blue_sample = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [SW-1:0]      m_trace_value;

    frame_t               frame_q[$];
    logic signed [SW-1:0] trace_q[$];
    frame_t               nxt;

    logic [TAU_W-1:0]     tau_cfg = TAU_RESET;
    logic [RATIO_W-1:0]   ratio_cfg = RATIO_RESET;
    logic signed [SW-1:0] prev_red = '0;
    logic signed [SW-1:0] prev_blue = '0;
    logic signed [SW-1:0] prev_trace = '0;

    logic       req_taken = 1'b0;
    int         gap_left = 0;
    int         burst_left = 1;
    int         gap_mode = 0;
    int         stall_mode = 0;
    int         tick = 0;
    int         cycle_count = 0;
    int         queued_count = 0;
    int         accepted_count = 0;
    int         checked_count = 0;
    int         settings_run = 1;
    int         errors = 0;
    logic signed [SW-1:0] want;

    total_trace_filter #(
        .SAMPLE_WIDTH(SW)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_index    (cfg_wr_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_frame   (s_first_frame),
        .s_frame_interval(s_frame_interval),
        .s_red_sample    (s_red_sample),
        .s_blue_sample   (s_blue_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_trace_value   (m_trace_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [SW-1:0] trace_step(
        input logic first,
        input logic [15:0] interval,
        input logic signed [SW-1:0] red,
        input logic signed [SW-1:0] blue
    );
        longint tw, dv, rq;
        logic signed [127:0] c_red, c_blue, c_bprev, c_decay, den;
        logic signed [127:0] r, b, rp, bp, yp, num, mag, quo, rem, lim;
        logic neg;
        tw = 2 * longint'((tau_cfg == '0) ? 16'd1 : tau_cfg);
        dv = longint'(interval);
        rq = longint'(ratio_cfg);
        c_red   = 4096 * tw;
        c_blue  = tw * rq + 4096 * dv;
        c_bprev = tw * rq - 4096 * dv;
        c_decay = 4096 * (tw - dv);
        den     = 4096 * (tw + dv);
        r  = red;
        b  = blue;
        rp = first ? 0 : prev_red;
        bp = first ? 0 : prev_blue;
        yp = first ? 0 : prev_trace;
        num = c_red * (r - rp) + c_blue * b - c_bprev * bp + c_decay * yp;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if (2 * rem >= den) begin
            quo = quo + 1;
        end
        lim = 128'sd1 << (SW - 1);
        if (!neg) begin
            lim = lim - 1;
        end
        if (quo > lim) begin
            quo = lim;
        end
        if (neg) begin
            quo = -quo;
        end
        prev_red   = red;
        prev_blue  = blue;
        prev_trace = quo[SW-1:0];
        return prev_trace;
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return '0;
            3: return '1;
            4, 5, 6, 7: return $urandom;
            default: return $urandom_range(0, 1 << 22) - (1 << 21);
        endcase
    endfunction

    function automatic logic [15:0] rand_interval();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return $urandom_range(0, 65535);
            default: return $urandom_range(128, 1024);
        endcase
    endfunction

    task automatic add_frame(input logic first, input logic [15:0] interval,
                             input logic signed [SW-1:0] red,
                             input logic signed [SW-1:0] blue, input logic drain);
        frame_t f;
        f.first    = first;
        f.interval = interval;
        f.red      = red;
        f.blue     = blue;
        f.drain    = drain;
        frame_q.push_back(f);
        queued_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        case (idx)
            CFG_TAU: tau_cfg = value;
            CFG_RATIO: ratio_cfg = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (accepted_count != queued_count || trace_q.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // request driver
    always @(negedge aclk) begin
        if (!s_valid || req_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (frame_q.size() != 0 && !(frame_q[0].drain && trace_q.size() != 0)) begin
                nxt = frame_q.pop_front();
                s_first_frame    <= nxt.first;
                s_frame_interval <= nxt.interval;
                s_red_sample     <= nxt.red;
                s_blue_sample    <= nxt.blue;
                s_valid          <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= (gap_mode == 0) ? 0 :
                                  (gap_mode == 1) ? $urandom_range(0, 4) : $urandom_range(0, 60);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge aclk) begin
        tick <= tick + 1;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 3) != 0;
            default: m_ready <= (tick % 128) >= 60;
        endcase
    end

    // request and result monitor
    always @(posedge aclk) begin
        req_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            trace_q.push_back(trace_step(s_first_frame, s_frame_interval,
                                         s_red_sample, s_blue_sample));
            accepted_count++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (trace_q.size() == 0) begin
                $error("trace_value: no result expected, actual %0d", m_trace_value);
                errors++;
            end else begin
                want = trace_q.pop_front();
                checked_count++;
                if (m_trace_value !== want) begin
                    $error("trace_value: expected %0d, actual %0d", want, m_trace_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [15:0] tau_plan [PHASES];
        logic [15:0] ratio_plan [PHASES];
        int done;
        int trace_len;
        tau_plan   = '{16'd1280, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1280, 16'd0, 16'd0};
        ratio_plan = '{16'd4096, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd4096, 16'd0, 16'd0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: tau 5.0, ratio 1.0
        add_frame(1'b1, 16'd256, 0, 0, 1'b0);
        add_frame(1'b1, 16'd2560, 1, 0, 1'b0);
        add_frame(1'b1, 16'd2560, -1, 0, 1'b0);
        add_frame(1'b1, 16'd2560, 3, 0, 1'b0);
        add_frame(1'b1, 16'd2560, -3, 0, 1'b0);
        add_frame(1'b0, 16'd0, 100, 5, 1'b0);
        add_frame(1'b0, 16'd0, -7, 12, 1'b0);
        add_frame(1'b1, 16'hFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        add_frame(1'b1, 16'd0, 32'sh80000000, 32'sh80000000, 1'b0);
        add_frame(1'b0, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        add_frame(1'b0, 16'd0, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
        add_frame(1'b0, 16'hFFFF, 0, 0, 1'b0);
        add_frame(1'b1, 16'd256, 32'sh00010000, 32'sh00008000, 1'b0);
        add_frame(1'b0, 16'd256, 32'sh00020000, 32'sh00008800, 1'b0);
        add_frame(1'b0, 16'd256, 32'sh00038000, 32'sh00009000, 1'b0);
        add_frame(1'b0, 16'd256, 32'sh00050000, 32'sh00008000, 1'b1);
        add_frame(1'b1, 16'd1, -1, -1, 1'b0);
        add_frame(1'b0, 16'd1, 32'shFFFF0000, 32'sh0000FFFF, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                write_reg(CFG_TAU, (p >= 6) ? 16'($urandom) : tau_plan[p]);
                write_reg(CFG_RATIO, (p >= 6) ? 16'($urandom) : ratio_plan[p]);
                settings_run++;
            end
            gap_mode   = p % 3;
            stall_mode = (p + 1) % 3;
            done = 0;
            while (done < PER_PHASE) begin
                trace_len = $urandom_range(1, 24);
                for (int k = 0; k < trace_len; k++) begin
                    add_frame((k == 0) ? 1'b1 : ($urandom_range(0, 19) == 0), rand_interval(),
                              rand_sample(), rand_sample(), $urandom_range(0, 49) == 0);
                end
                done += trace_len;
            end
        end

        wait_idle();
        repeat (SETTLE) @(negedge aclk);
        $display("covered %0d frames over %0d register settings, %0d trace values checked",
                 accepted_count, settings_run, checked_count);
        if (errors == 0 && trace_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ttf_pkg.sv
hw/rtl/ttf_ctrl.sv
hw/rtl/ttf_datapath.sv
hw/rtl/total_trace_filter.sv
hw/rtl/ttf_chk.sv
tb/sv/total_trace_filter_tb.sv
